// File: hdl/mfrb_pkg.sv
// shared types and constants of the median filter core
// no dependencies

package mfrb_pkg;

   // configuration register indexes
   localparam logic [1:0] REG_IMG_WIDTH   = 2'd0;
   localparam logic [1:0] REG_IMG_HEIGHT  = 2'd1;
   localparam logic [1:0] REG_KERNEL_SIZE = 2'd2;

   // request codes
   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_DRAIN = 1'b1;

   // reset values of the configuration registers
   localparam logic [10:0] IMG_WIDTH_RST   = 11'd1024;
   localparam logic [12:0] IMG_HEIGHT_RST  = 13'd4096;
   localparam logic [2:0]  KERNEL_SIZE_RST = 3'd3;

   localparam logic [7:0] PIX_MIN = 8'd0;
   localparam logic [7:0] PIX_MAX = 8'd255;

   typedef struct packed {
      logic       req_type;
      logic [7:0] pixel_in;
   } mfrb_req_type;

   typedef struct packed {
      logic [7:0]  median_out;
      logic [9:0]  out_col;
      logic [11:0] out_row;
      logic        frame_last;
   } mfrb_rsp_type;

   // link between neighbouring sorter cells
   typedef struct packed {
      logic       valid;
      logic       gt;
      logic [7:0] value;
   } mfrb_link_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_PAD,
      ST_GATHER,
      ST_FLUSH,
      ST_EMIT
   } mfrb_state_type;

endpackage

// File: hdl/mfrb_ram.sv
// generic simple dual port ram, registered read
// no dependencies

module mfrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/mfrb_cell.sv
// one cell of the insertion sorting chain
// depends on mfrb_pkg

module mfrb_cell (
   input  logic                  clock,
   input  logic                  clear,
   input  logic                  ins_valid,
   input  logic [7:0]            ins_data,
   input  mfrb_pkg::mfrb_link_type prev_link,
   output mfrb_pkg::mfrb_link_type own_link
);
   import mfrb_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] value_ff, value_in;
   logic       gt;

   // empty cells count as larger than anything
   assign gt = !valid_ff || (value_ff > ins_data);

   // take the new value or the lower neighbour's, else hold
   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (clear) begin
         valid_in = 1'b0;
      end else if (ins_valid && gt) begin
         if (prev_link.gt) begin
            valid_in = prev_link.valid;
            value_in = prev_link.value;
         end else begin
            valid_in = 1'b1;
            value_in = ins_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (clear) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign own_link = '{valid: valid_ff, gt: gt, value: value_ff};

endmodule

// File: hdl/median_filter_replicate_border_core.sv
// median filter with replicated border: top level, line store, sequencer, sorting chain
// depends on mfrb_pkg, mfrb_ram, mfrb_cell
// a request with no result returns to idle from the check state; one with a result
// passes pad (unless the window fills the chain), gather, flush and emit; one sorter
// insert per cycle over the padded window, one line store read per window pixel
// throughput: one request at a time; the result register lets the next request in
// reset: synchronous, clears counters, sequencer and result valid; line store needs none

module median_filter_replicate_border_core #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096,
   parameter int MAX_K      = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  mfrb_pkg::mfrb_req_type req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output mfrb_pkg::mfrb_rsp_type rsp_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [12:0]           csr_data
);
   import mfrb_pkg::*;

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int RMAX  = MAX_K / 2;
   localparam int RBW   = $clog2(RMAX + 1);
   localparam int DW    = RBW + 1;
   localparam int CELLS = (2 * RMAX + 1) * (2 * RMAX + 1);
   localparam int NW    = $clog2(CELLS + 1);
   localparam int SRB   = $clog2(MAX_K + 1);
   localparam int AW    = SRB + CW;
   localparam int MID   = CELLS / 2;

   // configuration registers
   logic [10:0] img_width_ff;
   logic [12:0] img_height_ff;
   logic [2:0]  kernel_size_ff;
   logic        cfg_wr;
   logic        cfg_restart;

   // effective geometry
   logic [CW-1:0]  wm1;
   logic [RW-1:0]  hm1;
   logic [RBW-1:0] rad;
   logic [1:0]     khalf;

   mfrb_state_type state_ff, state_in;

   logic [CW-1:0] in_col_ff, in_col_in, ec_ff, ec_in;
   logic [RW-1:0] in_row_ff, in_row_in, er_ff, er_in;
   logic          in_done_ff, in_done_in;
   logic [NW-1:0] pad_ff, pad_in, cnt_ff, cnt_in;
   logic signed [DW-1:0] dy_ff, dy_in, dx_ff, dx_in;
   logic          rd_pend_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   mfrb_rsp_type  rsp_ff, rsp_in;

   logic          accept, pix_wr, ready, last, rd_en, clear, ins_valid;
   logic [7:0]    ins_data, rd_data;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [RW:0]   need_row;
   logic [CW:0]   need_col;
   logic [NW-1:0] n_win;
   logic signed [RW+1:0] row_s;
   logic signed [CW+1:0] col_s;
   logic [RW-1:0] row_c;
   logic [CW-1:0] col_c;
   logic signed [DW-1:0] rad_s;

   mfrb_link_type links [CELLS+1];

   assign accept    = (state_ff == ST_IDLE) && req_valid;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign cfg_wr    = csr_valid && csr_ready;
   assign pix_wr    = accept && (req_payload.req_type == REQ_PIXEL) && !in_done_ff;

   // only a write to a known register restarts the frame
   assign cfg_restart = cfg_wr && (csr_index == REG_IMG_WIDTH ||
                                   csr_index == REG_IMG_HEIGHT ||
                                   csr_index == REG_KERNEL_SIZE);

   // clamp the register values into range
   always_comb begin
      if (img_width_ff == '0) begin
         wm1 = '0;
      end else if (32'(img_width_ff) > MAX_WIDTH) begin
         wm1 = CW'(MAX_WIDTH - 1);
      end else begin
         wm1 = CW'(32'(img_width_ff) - 1);
      end
      if (img_height_ff == '0) begin
         hm1 = '0;
      end else if (32'(img_height_ff) > MAX_HEIGHT) begin
         hm1 = RW'(MAX_HEIGHT - 1);
      end else begin
         hm1 = RW'(32'(img_height_ff) - 1);
      end
      khalf = kernel_size_ff[2:1];
      if (32'(khalf) > RMAX) begin
         rad = RBW'(RMAX);
      end else begin
         rad = RBW'(khalf);
      end
   end

   assign rad_s = $signed({1'b0, rad});

   // readiness of the next output position
   always_comb begin
      need_row = {1'b0, er_ff} + (RW+1)'(rad);
      if (need_row > {1'b0, hm1}) begin
         need_row = {1'b0, hm1};
      end
      need_col = {1'b0, ec_ff} + (CW+1)'(rad);
      if (need_col > {1'b0, wm1}) begin
         need_col = {1'b0, wm1};
      end
      ready = in_done_ff || (need_row[RW-1:0] < in_row_ff) ||
              ((need_row[RW-1:0] == in_row_ff) && (need_col[CW-1:0] < in_col_ff));
      last  = (er_ff == hm1) && (ec_ff == wm1);
   end

   // clamped window coordinate of the current read
   always_comb begin
      row_s = $signed({2'b00, er_ff}) + $signed({{(RW+2-DW){dy_ff[DW-1]}}, dy_ff});
      col_s = $signed({2'b00, ec_ff}) + $signed({{(CW+2-DW){dx_ff[DW-1]}}, dx_ff});
      if (row_s[RW+1]) begin
         row_c = '0;
      end else if (row_s[RW:0] > {1'b0, hm1}) begin
         row_c = hm1;
      end else begin
         row_c = row_s[RW-1:0];
      end
      if (col_s[CW+1]) begin
         col_c = '0;
      end else if (col_s[CW:0] > {1'b0, wm1}) begin
         col_c = wm1;
      end else begin
         col_c = col_s[CW-1:0];
      end
   end

   assign wr_addr = {in_row_ff[SRB-1:0], in_col_ff};
   assign rd_addr = {row_c[SRB-1:0], col_c};
   assign rd_en   = (state_ff == ST_GATHER);

   // window size from the radius; the pad count follows from it in the check state
   assign n_win = NW'((2 * 32'(rad) + 1) * (2 * 32'(rad) + 1));

   // sequencer
   always_comb begin
      state_in     = state_ff;
      in_col_in    = in_col_ff;
      in_row_in    = in_row_ff;
      in_done_in   = in_done_ff;
      ec_in        = ec_ff;
      er_in        = er_ff;
      pad_in       = pad_ff;
      cnt_in       = cnt_ff;
      dy_in        = dy_ff;
      dx_in        = dx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CHECK;
            end
            if (pix_wr) begin
               if (in_col_ff == wm1) begin
                  in_col_in = '0;
                  if (in_row_ff == hm1) begin
                     in_row_in  = '0;
                     in_done_in = 1'b1;
                  end else begin
                     in_row_in = in_row_ff + 1'b1;
                  end
               end else begin
                  in_col_in = in_col_ff + 1'b1;
               end
            end
         end
         ST_CHECK: begin
            pad_in = NW'((CELLS - 32'(n_win)) / 2);
            cnt_in = '0;
            dy_in  = -rad_s;
            dx_in  = -rad_s;
            if (!ready) begin
               state_in = ST_IDLE;
            end else if (32'(n_win) == CELLS) begin
               state_in = ST_GATHER;
            end else begin
               state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == NW'({pad_ff, 1'b0} - 1'b1)) begin
               state_in = ST_GATHER;
            end
         end
         ST_GATHER: begin
            if (dx_ff == rad_s) begin
               dx_in = -rad_s;
               if (dy_ff == rad_s) begin
                  state_in = ST_FLUSH;
               end else begin
                  dy_in = dy_ff + 1'b1;
               end
            end else begin
               dx_in = dx_ff + 1'b1;
            end
         end
         ST_FLUSH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in.median_out = links[MID+1].value;
               rsp_in.out_col    = 10'(ec_ff);
               rsp_in.out_row    = 12'(er_ff);
               rsp_in.frame_last = last;
               if (last) begin
                  in_col_in  = '0;
                  in_row_in  = '0;
                  in_done_in = 1'b0;
                  ec_in      = '0;
                  er_in      = '0;
               end else if (ec_ff == wm1) begin
                  ec_in = '0;
                  er_in = er_ff + 1'b1;
               end else begin
                  ec_in = ec_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // a write to a known register restarts the frame
      if (cfg_restart) begin
         in_col_in  = '0;
         in_row_in  = '0;
         in_done_in = 1'b0;
         ec_in      = '0;
         er_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         in_col_ff      <= '0;
         in_row_ff      <= '0;
         in_done_ff     <= 1'b0;
         ec_ff          <= '0;
         er_ff          <= '0;
         rd_pend_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         img_width_ff   <= IMG_WIDTH_RST;
         img_height_ff  <= IMG_HEIGHT_RST;
         kernel_size_ff <= KERNEL_SIZE_RST;
      end else begin
         state_ff     <= state_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         in_done_ff   <= in_done_in;
         ec_ff        <= ec_in;
         er_ff        <= er_in;
         rd_pend_ff   <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
         if (cfg_wr) begin
            unique case (csr_index)
               REG_IMG_WIDTH:   img_width_ff   <= csr_data[10:0];
               REG_IMG_HEIGHT:  img_height_ff  <= csr_data;
               REG_KERNEL_SIZE: kernel_size_ff <= csr_data[2:0];
               default: ;
            endcase
         end
      end
      pad_ff <= pad_in;
      cnt_ff <= cnt_in;
      dy_ff  <= dy_in;
      dx_ff  <= dx_in;
      rsp_ff <= rsp_in;
   end

   // line store
   mfrb_ram #(
      .WIDTH(8),
      .DEPTH(1 << AW)
   ) u_line_store (
      .clock  (clock),
      .wr_en  (pix_wr),
      .wr_addr(wr_addr),
      .wr_data(req_payload.pixel_in),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // insert stream: low and high pads keep the median in the middle cell
   always_comb begin
      clear     = (state_ff == ST_CHECK);
      ins_valid = rd_pend_ff || (state_ff == ST_PAD);
      if (rd_pend_ff) begin
         ins_data = rd_data;
      end else if (cnt_ff < pad_ff) begin
         ins_data = PIX_MIN;
      end else begin
         ins_data = PIX_MAX;
      end
   end

   // sorting chain, lowest value in the first cell
   assign links[0] = '{valid: 1'b0, gt: 1'b0, value: '0};

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      mfrb_cell u_cell (
         .clock    (clock),
         .clear    (clear),
         .ins_valid(ins_valid),
         .ins_data (ins_data),
         .prev_link(links[i]),
         .own_link (links[i+1])
      );
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: hdl/mfrb_checker.sv
// port level checks of the median filter core, bound to the top level
// depends on mfrb_pkg and median_filter_replicate_border_core

module mfrb_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input mfrb_pkg::mfrb_rsp_type rsp_payload
);
   import mfrb_pkg::*;

   // no result straight after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a new result only comes out of a busy block
   a_rise_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared while idle");

   // a stalled result stays
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result dropped");

   // a stalled result holds its payload
   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_payload))
      else $error("stalled result changed");

endmodule

bind median_filter_replicate_border_core mfrb_checker u_mfrb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_payload(rsp_payload)
);

// File: bench/median_filter_checker.sv
`timescale 1ns / 1ps
// checker for the median filter core: watches the request, result and register channels,
// predicts every result and compares it field by field; depends on mfrb_pkg

module median_filter_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  mfrb_pkg::mfrb_req_type req_payload,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  mfrb_pkg::mfrb_rsp_type rsp_payload,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [12:0]            csr_data,
   output int                     outstanding,
   output int                     fail_count
);
   import mfrb_pkg::*;

   localparam int STORE_W    = 1024;
   localparam int STORE_ROWS = 8;
   localparam int MAX_W      = 1024;
   localparam int MAX_H      = 4096;
   localparam int MAX_RAD    = 3;

   logic [7:0]   line_mem [STORE_ROWS*STORE_W];
   logic [10:0]  cfg_width;
   logic [12:0]  cfg_height;
   logic [2:0]   cfg_kernel;
   int           in_col, in_row, emit_col, emit_row;
   bit           frame_full;
   mfrb_rsp_type median_q[$];
   int           fails = 0;

   assign outstanding = median_q.size();
   assign fail_count  = fails;

   function automatic int eff_width();
      if (cfg_width == 0) return 1;
      if (cfg_width > MAX_W) return MAX_W;
      return int'(cfg_width);
   endfunction

   function automatic int eff_height();
      if (cfg_height == 0) return 1;
      if (cfg_height > MAX_H) return MAX_H;
      return int'(cfg_height);
   endfunction

   function automatic int eff_radius();
      int r;
      r = int'(cfg_kernel) / 2;
      return (r > MAX_RAD) ? MAX_RAD : r;
   endfunction

   function automatic int clamp_to(int v, int n);
      if (v < 0) return 0;
      if (v >= n) return n - 1;
      return v;
   endfunction

   // gather the clamped window and pick the middle of the sorted values
   function automatic logic [7:0] window_median(int er, int ec, int r, int w, int h);
      int vals [49];
      int n, row, col, v, j;
      n = 0;
      for (int dy = -r; dy <= r; dy++) begin
         row = clamp_to(er + dy, h);
         for (int dx = -r; dx <= r; dx++) begin
            col = clamp_to(ec + dx, w);
            vals[n] = line_mem[(row % STORE_ROWS)*STORE_W + (col % STORE_W)];
            n++;
         end
      end
      for (int i = 1; i < n; i++) begin
         v = vals[i];
         j = i;
         while (j > 0 && vals[j-1] > v) begin
            vals[j] = vals[j-1];
            j--;
         end
         vals[j] = v;
      end
      return vals[n/2][7:0];
   endfunction

   task automatic restart_frame();
      in_col     = 0;
      in_row     = 0;
      frame_full = 0;
      emit_col   = 0;
      emit_row   = 0;
   endtask

   // one request: store the pixel, then emit the oldest ready position if any
   task automatic predict_request(mfrb_req_type rq);
      int w, h, r, need_row, need_col;
      bit ready, last;
      mfrb_rsp_type res;
      w = eff_width();
      h = eff_height();
      r = eff_radius();
      if (rq.req_type == REQ_PIXEL && !frame_full) begin
         line_mem[(in_row % STORE_ROWS)*STORE_W + (in_col % STORE_W)] = rq.pixel_in;
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
            if (in_row >= h) begin
               in_row     = 0;
               frame_full = 1;
            end
         end
      end
      need_row = (emit_row + r > h - 1) ? h - 1 : emit_row + r;
      need_col = (emit_col + r > w - 1) ? w - 1 : emit_col + r;
      ready = frame_full || need_row < in_row || (need_row == in_row && need_col < in_col);
      if (ready) begin
         last           = (emit_row == h - 1) && (emit_col == w - 1);
         res.median_out = window_median(emit_row, emit_col, r, w, h);
         res.out_col    = emit_col[9:0];
         res.out_row    = emit_row[11:0];
         res.frame_last = last;
         median_q       = {median_q, res};
         if (last) begin
            restart_frame();
         end else begin
            emit_col++;
            if (emit_col >= w) begin
               emit_col = 0;
               emit_row++;
            end
         end
      end
   endtask

   task automatic report(string field, int want, int got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      fails++;
   endtask

   always @(posedge clock) begin
      mfrb_rsp_type want;
      if (reset) begin
         cfg_width  = IMG_WIDTH_RST;
         cfg_height = IMG_HEIGHT_RST;
         cfg_kernel = KERNEL_SIZE_RST;
         restart_frame();
         median_q.delete();
      end else begin
         // results first, a request cannot produce one at its own edge
         if (rsp_valid && !rsp_stall) begin
            if (median_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h",
                        $time, rsp_payload);
               fails++;
            end else begin
               want = median_q.pop_front();
               if (rsp_payload.median_out !== want.median_out)
                  report("median_out", want.median_out, rsp_payload.median_out);
               if (rsp_payload.out_col !== want.out_col)
                  report("out_col", want.out_col, rsp_payload.out_col);
               if (rsp_payload.out_row !== want.out_row)
                  report("out_row", want.out_row, rsp_payload.out_row);
               if (rsp_payload.frame_last !== want.frame_last)
                  report("frame_last", want.frame_last, rsp_payload.frame_last);
            end
         end
         // register writes restart the frame, unknown index does nothing
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_IMG_WIDTH: begin
                  cfg_width = csr_data[10:0];
                  restart_frame();
               end
               REG_IMG_HEIGHT: begin
                  cfg_height = csr_data;
                  restart_frame();
               end
               REG_KERNEL_SIZE: begin
                  cfg_kernel = csr_data[2:0];
                  restart_frame();
               end
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict_request(req_payload);
      end
   end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// top of the median filter bench: clock, reset, request and register stimulus, verdict
// depends on mfrb_pkg, median_filter_replicate_border_core and median_filter_checker

module testbench;
   import mfrb_pkg::*;

   localparam logic [1:0] REG_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 80;
   localparam int RANDOM_REQUESTS = 1100;
   localparam int EDGE_PIXELS = 40;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   mfrb_req_type req_payload;
   logic         rsp_valid;
   logic         rsp_stall;
   mfrb_rsp_type rsp_payload;
   logic         csr_valid;
   logic         csr_ready;
   logic [1:0]   csr_index;
   logic [12:0]  csr_data;
   int           outstanding, fail_count;

   bit idle_on;
   int stall_left;
   int requests_sent;
   int cur_w, cur_h, cur_r;

   median_filter_replicate_border_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   median_filter_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data), .outstanding(outstanding), .fail_count(fail_count)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("simulation failed");
      $finish;
   end

   // result side back-pressure: a fresh stall length after every accepted result
   always @(posedge clock) begin
      int n;
      if (reset) begin
         rsp_stall  <= 0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         n = idle_on ? $urandom_range(0, 17) : 0;
         stall_left <= n;
         rsp_stall  <= (n != 0);
      end else if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else begin
         stall_left <= 0;
         rsp_stall  <= 0;
      end
   end

   task automatic send_request(logic kind, logic [7:0] pix);
      int gap;
      gap = idle_on ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid            <= 1;
      req_payload.req_type <= kind;
      req_payload.pixel_in <= pix;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
   endtask

   // wait until every expected result is back and the core has gone quiet
   task automatic settle();
      req_valid <= 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [12:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
   endtask

   // write all three registers and keep the effective frame geometry
   task automatic configure(logic [12:0] w_data, logic [12:0] h_data, logic [12:0] k_data);
      int kr;
      if ($urandom_range(0, 5) == 0) csr_write(REG_UNUSED, 13'($urandom));
      csr_write(REG_IMG_WIDTH, w_data);
      csr_write(REG_IMG_HEIGHT, h_data);
      csr_write(REG_KERNEL_SIZE, k_data);
      cur_w = (w_data[10:0] == 0) ? 1 : (w_data[10:0] > 1024) ? 1024 : int'(w_data[10:0]);
      cur_h = (h_data == 0) ? 1 : (h_data > 4096) ? 4096 : int'(h_data);
      kr    = int'(k_data[2:0]) / 2;
      cur_r = kr;
   endtask

   function automatic logic [7:0] random_pixel();
      case ($urandom_range(0, 7))
         0: return PIX_MIN;
         1: return PIX_MAX;
         2: return 8'($urandom_range(100, 103));
         default: return 8'($urandom);
      endcase
   endfunction

   // one frame with stray drain ticks, optionally cut short, then the drain tail for a whole frame
   task automatic run_frame(bit whole);
      int total, n, tail;
      total = cur_w * cur_h;
      n = whole ? total : $urandom_range(0, total - 1);
      for (int i = 0; i < n; i++) begin
         if (whole && $urandom_range(0, 9) == 0) send_request(REQ_DRAIN, 8'($urandom));
         send_request(REQ_PIXEL, random_pixel());
      end
      if (whole) begin
         tail = (cur_r + 1) * cur_w + cur_r + 2;
         for (int i = 0; i < tail; i++) begin
            // pixels once the frame is full only push the drain along
            if (i < 3 && $urandom_range(0, 1) == 0)
               send_request(REQ_PIXEL, random_pixel());
            else
               send_request(REQ_DRAIN, 8'($urandom));
         end
      end
      settle();
   endtask

   // the start of a large frame only, then wait for its results
   task automatic run_start(int n);
      for (int i = 0; i < n; i++) send_request(REQ_PIXEL, random_pixel());
      settle();
   endtask

   initial begin
      reset         = 1;
      req_valid     = 0;
      req_payload   = '0;
      csr_valid     = 0;
      csr_index     = REG_IMG_WIDTH;
      csr_data      = '0;
      idle_on       = 1;
      requests_sent = 0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: small 3x3 frame, drain with nothing ready, extreme pixels
      configure(13'd3, 13'd3, 13'd3);
      send_request(REQ_DRAIN, PIX_MAX);
      send_request(REQ_PIXEL, PIX_MIN);
      send_request(REQ_PIXEL, PIX_MAX);
      send_request(REQ_PIXEL, 8'd17);
      send_request(REQ_PIXEL, PIX_MAX);
      send_request(REQ_PIXEL, PIX_MIN);
      send_request(REQ_PIXEL, 8'd128);
      send_request(REQ_PIXEL, 8'd1);
      send_request(REQ_PIXEL, 8'd254);
      send_request(REQ_PIXEL, PIX_MAX);
      for (int i = 0; i < 7; i++) send_request(REQ_DRAIN, PIX_MIN);
      settle();
      // kernel of one: output equals input
      configure(13'd2, 13'd1, 13'd1);
      send_request(REQ_PIXEL, PIX_MAX);
      send_request(REQ_PIXEL, PIX_MIN);
      send_request(REQ_DRAIN, PIX_MIN);
      settle();

      // random frames of small size, upper width and kernel register bits toggled
      while (requests_sent < RANDOM_REQUESTS) begin
         idle_on = ($urandom_range(0, 2) != 0);
         configure({2'($urandom), 11'($urandom_range(0, 9))},
                   13'($urandom_range(0, 8)),
                   {10'($urandom), 3'($urandom)});
         run_frame($urandom_range(0, 5) != 0);
      end

      // largest and saturating register values, the first pixels of each frame
      idle_on = 0;
      configure(13'd1024, 13'd1, 13'd7);
      run_start(EDGE_PIXELS);
      configure(13'd2047, 13'd2, 13'd6);
      run_start(EDGE_PIXELS);
      configure(13'd0, 13'd8191, 13'd5);
      run_start(EDGE_PIXELS);
      configure(13'd1, 13'd4096, 13'd0);
      run_start(EDGE_PIXELS);

      settle();
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
